// ===== rtl/ksib_pkg.sv =====
// Shared types and constants for the k-mer seed index builder.
// Has no dependencies; every other file of the block imports it.
package ksib_pkg;

  localparam int BUCKET_W    = 20;
  localparam int NUM_BUCKETS = 1 << BUCKET_W;
  localparam int CHUNK_W     = 12;
  localparam int STOP_W      = 16;
  localparam int SLOT_W      = 2;
  localparam int FILL_OUT_W  = 3;
  localparam int CFG_W       = 3;

  localparam int SEED_LENGTH_DEF    = 10;
  localparam int SAMPLE_STEP_DEF    = 1;
  localparam int MAX_PER_BUCKET_DEF = 4;
  localparam int CHUNK_LEN_DEF      = 65536;

  localparam logic [CFG_W-1:0] CAP_RESET = 3'd4;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic commit;
  } ksib_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } ksib_status_t;

endpackage

// ===== rtl/ksib_if.sv =====
// Valid/ready channel interfaces for the request and response items.
// Depends on ksib_pkg for the field widths.
interface ksib_req_if;
  import ksib_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [1:0]          nucleotide;
  logic                chunk_start;
  logic [CHUNK_W-1:0]  chunk_number;
  logic [BUCKET_W-1:0] query_bucket;
  logic [SLOT_W-1:0]   query_slot;

  modport source (
    output valid, kind, nucleotide, chunk_start, chunk_number, query_bucket, query_slot,
    input  ready
  );
  modport sink (
    input  valid, kind, nucleotide, chunk_start, chunk_number, query_bucket, query_slot,
    output ready
  );
endinterface

interface ksib_rsp_if;
  import ksib_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  recorded;
  logic                  dropped;
  logic [BUCKET_W-1:0]   bucket;
  logic [SLOT_W-1:0]     slot_used;
  logic [FILL_OUT_W-1:0] bucket_fill;
  logic [CHUNK_W-1:0]    hit_chunk;
  logic [STOP_W-1:0]     hit_stop;
  logic                  hit_valid;

  modport source (
    output valid, recorded, dropped, bucket, slot_used, bucket_fill, hit_chunk, hit_stop,
    output hit_valid,
    input  ready
  );
  modport sink (
    input  valid, recorded, dropped, bucket, slot_used, bucket_fill, hit_chunk, hit_stop,
    input  hit_valid,
    output ready
  );
endinterface

// ===== rtl/ksib_ctrl.sv =====
// Controller state machine: clearing pass, item acceptance and commit.
// Depends on ksib_pkg for the command and status structs.
module ksib_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  ksib_pkg::ksib_status_t status,
  output logic                   req_ready,
  output ksib_pkg::ksib_cmd_t    cmd
);
  import ksib_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/ksib_datapath.sv =====
// Datapath: seed window, position tracking, fill and location memories, output register.
// Depends on ksib_pkg; driven by ksib_ctrl through the command struct.
module ksib_datapath #(
  parameter int SEED_LENGTH    = ksib_pkg::SEED_LENGTH_DEF,
  parameter int SAMPLE_STEP    = ksib_pkg::SAMPLE_STEP_DEF,
  parameter int MAX_PER_BUCKET = ksib_pkg::MAX_PER_BUCKET_DEF,
  parameter int CHUNK_LEN      = ksib_pkg::CHUNK_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ksib_pkg::ksib_cmd_t             cmd,
  output ksib_pkg::ksib_status_t          status,
  input  logic                            cfg_wr_en,
  input  logic [ksib_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                            req_kind,
  input  logic [1:0]                      req_nucleotide,
  input  logic                            req_chunk_start,
  input  logic [ksib_pkg::CHUNK_W-1:0]    req_chunk_number,
  input  logic [ksib_pkg::BUCKET_W-1:0]   req_query_bucket,
  input  logic [ksib_pkg::SLOT_W-1:0]     req_query_slot,
  input  logic                            rsp_ready,
  output logic                            rsp_valid,
  output logic                            rsp_recorded,
  output logic                            rsp_dropped,
  output logic [ksib_pkg::BUCKET_W-1:0]   rsp_bucket,
  output logic [ksib_pkg::SLOT_W-1:0]     rsp_slot_used,
  output logic [ksib_pkg::FILL_OUT_W-1:0] rsp_bucket_fill,
  output logic [ksib_pkg::CHUNK_W-1:0]    rsp_hit_chunk,
  output logic [ksib_pkg::STOP_W-1:0]     rsp_hit_stop,
  output logic                            rsp_hit_valid
);
  import ksib_pkg::*;

  localparam int POS_W     = $clog2(CHUNK_LEN + 1);
  localparam int PHASE_W   = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
  localparam int FILL_W    = $clog2(MAX_PER_BUCKET + 1);
  localparam int CMP_W     = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam int LOC_W     = CHUNK_W + STOP_W;
  localparam int LOC_DEPTH = NUM_BUCKETS * MAX_PER_BUCKET;
  localparam int LOC_AW    = $clog2(LOC_DEPTH);
  localparam int SEED_KEEP = (SEED_LENGTH < 10) ? SEED_LENGTH : 10;

  localparam logic [BUCKET_W-1:0] WINDOW_MASK =
    BUCKET_W'((64'd1 << (2 * SEED_KEEP)) - 64'd1);
  localparam logic [PHASE_W-1:0] SAMPLE_PHASE = PHASE_W'(SEED_LENGTH % SAMPLE_STEP);
  localparam logic [PHASE_W-1:0] PHASE_LAST   = PHASE_W'(SAMPLE_STEP - 1);

  logic [CFG_W-1:0]    cap_cfg;
  logic [BUCKET_W-1:0] window_seed;
  logic [POS_W-1:0]    position_count;
  logic [PHASE_W-1:0]  phase;
  logic [BUCKET_W-1:0] clr_addr;

  logic                item_kind;
  logic                item_sample;
  logic [BUCKET_W-1:0] item_bucket;
  logic [LOC_AW-1:0]   item_base_addr;
  logic [SLOT_W-1:0]   item_slot;
  logic [CHUNK_W-1:0]  item_chunk;
  logic [STOP_W-1:0]   item_stop;

  logic [FILL_W-1:0]   fill_mem [NUM_BUCKETS];
  logic [FILL_W-1:0]   fill_rdata;
  logic [LOC_W-1:0]    loc_mem [LOC_DEPTH];
  logic [LOC_W-1:0]    loc_rdata;

  logic [POS_W-1:0]        pos;
  logic [POS_W:0]          pos_inc;
  logic [POS_W-1:0]        pos_sat;
  logic [POS_W+STOP_W-1:0] pos_ext;
  logic [PHASE_W-1:0]      phase_cur;
  logic [PHASE_W-1:0]      phase_inc;
  logic [BUCKET_W-1:0]     seed_next;
  logic                    sample;
  logic [BUCKET_W-1:0]     sel_bucket;
  logic [LOC_AW-1:0]       base_addr;
  logic [LOC_AW-1:0]       query_addr;

  logic [CMP_W-1:0]  fill_ext;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  mpb_ext;
  logic [CMP_W-1:0]  cap;
  logic [CMP_W-1:0]  slot_ext;
  logic [CMP_W-1:0]  fill_after_ext;
  logic [FILL_W-1:0] fill_plus;
  logic [FILL_W-1:0] fill_after;
  logic              do_record;
  logic              do_drop;
  logic              hit;
  logic              fill_we;

  // Insert-side arithmetic and the query address, evaluated in the accept cycle.
  always_comb begin
    pos       = req_chunk_start ? '0 : position_count;
    pos_inc   = {1'b0, pos} + (POS_W + 1)'(1);
    pos_sat   = (pos_inc < (POS_W + 1)'(CHUNK_LEN)) ? pos_inc[POS_W-1:0] : POS_W'(CHUNK_LEN);
    pos_ext   = {{STOP_W{1'b0}}, pos};
    phase_cur = req_chunk_start ? '0 : phase;
    phase_inc = (phase_cur == PHASE_LAST) ? '0 : phase_cur + PHASE_W'(1);
    seed_next = {window_seed[BUCKET_W-3:0], req_nucleotide} & WINDOW_MASK;
    sample    = (pos_inc <= (POS_W + 1)'(CHUNK_LEN)) &&
                (pos_inc >= (POS_W + 1)'(SEED_LENGTH)) &&
                (phase_inc == SAMPLE_PHASE);
    sel_bucket = (req_kind == KIND_QUERY) ? req_query_bucket : seed_next;
    base_addr  = LOC_AW'(sel_bucket) * LOC_AW'(MAX_PER_BUCKET);
    query_addr = base_addr + LOC_AW'(req_query_slot);
  end

  // Decision logic, evaluated in the commit cycle on the registered fill.
  always_comb begin
    fill_ext       = CMP_W'(fill_rdata);
    cap_ext        = CMP_W'(cap_cfg);
    mpb_ext        = CMP_W'(MAX_PER_BUCKET);
    cap            = (cap_ext < mpb_ext) ? cap_ext : mpb_ext;
    do_record      = (item_kind == KIND_INSERT) && item_sample && (fill_ext < cap);
    do_drop        = (item_kind == KIND_INSERT) && item_sample && !(fill_ext < cap);
    fill_plus      = fill_rdata + FILL_W'(1);
    fill_after     = do_record ? fill_plus : fill_rdata;
    fill_after_ext = CMP_W'(fill_after);
    slot_ext       = CMP_W'(item_slot);
    hit            = (item_kind == KIND_QUERY) && (slot_ext < fill_ext) && (slot_ext < mpb_ext);
    fill_we        = cmd.commit && do_record;
  end

  assign status.clear_last = &clr_addr;
  assign status.out_free   = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_cfg        <= CAP_RESET;
      window_seed    <= '0;
      position_count <= '0;
      phase          <= '0;
      clr_addr       <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_cfg <= cfg_wr_data;
      end
      if (cmd.clear_en) begin
        clr_addr <= clr_addr + BUCKET_W'(1);
      end
      if (cmd.accept && (req_kind == KIND_INSERT)) begin
        window_seed    <= seed_next;
        position_count <= pos_sat;
        phase          <= phase_inc;
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind      <= req_kind;
      item_sample    <= (req_kind == KIND_INSERT) && sample;
      item_bucket    <= sel_bucket;
      item_base_addr <= base_addr;
      item_slot      <= req_query_slot;
      item_chunk     <= req_chunk_number;
      item_stop      <= pos_ext[STOP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      fill_mem[clr_addr] <= '0;
    end else if (fill_we) begin
      fill_mem[item_bucket] <= fill_plus;
    end
    if (cmd.accept) begin
      fill_rdata <= fill_mem[sel_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      loc_mem[item_base_addr + LOC_AW'(fill_rdata)] <= {item_chunk, item_stop};
    end
    if (cmd.accept) begin
      loc_rdata <= loc_mem[query_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_recorded    <= do_record;
      rsp_dropped     <= do_drop;
      rsp_bucket      <= item_bucket;
      rsp_bucket_fill <= fill_after_ext[FILL_OUT_W-1:0];
      rsp_hit_valid   <= hit;
      rsp_hit_chunk   <= hit ? loc_rdata[LOC_W-1:STOP_W] : '0;
      rsp_hit_stop    <= hit ? loc_rdata[STOP_W-1:0] : '0;
      if (item_kind == KIND_QUERY) begin
        rsp_slot_used <= item_slot;
      end else begin
        rsp_slot_used <= do_record ? fill_ext[SLOT_W-1:0] : '0;
      end
    end
  end

endmodule

// ===== rtl/kmer_seed_index_builder_top.sv =====
// Top level of the k-mer seed index builder: controller plus datapath.
// Depends on ksib_pkg, ksib_if, ksib_ctrl and ksib_datapath.
//
// The bucket's fill counter sits in a memory with a registered read, so an item is accepted
// in the idle state and its read-modify-write commits in the lookup state, after which the
// next item can be accepted. A finished result waits in the output register and a new item
// is taken meanwhile; the commit only stalls when that register is full and not being read.
// After reset a clearing pass zeroes the 1,048,576 fill counters, one per cycle, and no item
// is accepted during those cycles. The cap register can be written at any time, including
// during the clearing pass.
module kmer_seed_index_builder_top #(
  parameter int SEED_LENGTH    = ksib_pkg::SEED_LENGTH_DEF,
  parameter int SAMPLE_STEP    = ksib_pkg::SAMPLE_STEP_DEF,
  parameter int MAX_PER_BUCKET = ksib_pkg::MAX_PER_BUCKET_DEF,
  parameter int CHUNK_LEN      = ksib_pkg::CHUNK_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ksib_pkg::CFG_W-1:0] cfg_wr_data,
  ksib_req_if.sink                   req,
  ksib_rsp_if.source                 rsp
);
  import ksib_pkg::*;

  ksib_cmd_t    cmd;
  ksib_status_t status;

  ksib_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .status    (status),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  ksib_datapath #(
    .SEED_LENGTH    (SEED_LENGTH),
    .SAMPLE_STEP    (SAMPLE_STEP),
    .MAX_PER_BUCKET (MAX_PER_BUCKET),
    .CHUNK_LEN      (CHUNK_LEN)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .req_kind         (req.kind),
    .req_nucleotide   (req.nucleotide),
    .req_chunk_start  (req.chunk_start),
    .req_chunk_number (req.chunk_number),
    .req_query_bucket (req.query_bucket),
    .req_query_slot   (req.query_slot),
    .rsp_ready        (rsp.ready),
    .rsp_valid        (rsp.valid),
    .rsp_recorded     (rsp.recorded),
    .rsp_dropped      (rsp.dropped),
    .rsp_bucket       (rsp.bucket),
    .rsp_slot_used    (rsp.slot_used),
    .rsp_bucket_fill  (rsp.bucket_fill),
    .rsp_hit_chunk    (rsp.hit_chunk),
    .rsp_hit_stop     (rsp.hit_stop),
    .rsp_hit_valid    (rsp.hit_valid)
  );

endmodule

// ===== rtl/ksib_checker.sv =====
// Port-level assertions for the k-mer seed index builder, bound to its top level.
// Depends on ksib_pkg and on the ports of kmer_seed_index_builder_top.
module ksib_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_recorded,
  input logic                         rsp_dropped,
  input logic                         rsp_hit_valid,
  input logic [ksib_pkg::BUCKET_W-1:0] rsp_bucket
);
  import ksib_pkg::*;

  // The block works on one item at a time.
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted in two consecutive cycles");

  // A new result only appears after a lookup, during which req_ready is low.
  a_result_follows_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared without a lookup cycle");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_recorded && rsp_dropped) &&
                  !(rsp_hit_valid && (rsp_recorded || rsp_dropped)))
    else $error("conflicting result flags");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bucket) && $stable(rsp_recorded))
    else $error("stalled result changed");

endmodule

bind kmer_seed_index_builder_top ksib_checker u_ksib_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_recorded  (rsp.recorded),
  .rsp_dropped   (rsp.dropped),
  .rsp_hit_valid (rsp.hit_valid),
  .rsp_bucket    (rsp.bucket)
);
